/* rtl/didct_pkg.sv */
// Shared types, constants and functions of the dequantizing 8x8 inverse DCT.
`timescale 1ns / 1ps
package didct_pkg;

  localparam int QUANT_TABLES_DEF = 4;
  localparam int WORD_W = 48;
  localparam int K_W = 18;
  localparam int SCALE_W = 30;
  localparam int CQ_W = 25;

  localparam logic signed [K_W-1:0] K_1414 = 18'sd23170;
  localparam logic signed [K_W-1:0] K_1847 = 18'sd30274;
  localparam logic signed [K_W-1:0] K_1082 = 18'sd17734;
  localparam logic signed [K_W-1:0] K_M2613 = -18'sd42813;

  typedef struct packed {
    logic              func;
    logic [1:0]        table_select;
    logic [5:0]        position;
    logic [7:0]        quant_value;
    logic signed [15:0] coeff_value;
    logic              block_end;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [5:0] pixel_index;
    logic       last;
  } out_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t vec_t [8];

  typedef struct packed {
    logic start;
    logic done;
  } pass_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DQ_RD,
    ST_DQ_MUL,
    ST_DQ_WR,
    ST_LD,
    ST_GO,
    ST_RUN,
    ST_XFER
  } state_e;

  localparam logic FUNC_QUANT = 1'b0;
  localparam logic FUNC_COEFF = 1'b1;

  localparam logic [5:0] ZZ_TO_NAT [64] = '{
     6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  localparam int AAN_SCALE [8] = '{16384, 22725, 21407, 19266, 16384, 12873, 8867, 4520};

  typedef logic [SCALE_W-1:0] scale_tab_t [64];

  function automatic scale_tab_t build_scale2();
    scale_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = SCALE_W'(AAN_SCALE[i / 8] * AAN_SCALE[i % 8]);
    end
    return t;
  endfunction

  localparam scale_tab_t SCALE2 = build_scale2();

  function automatic logic [7:0] to_pixel(word_t v);
    word_t             sum;
    logic signed [10:0] s;
    sum = v + word_t'(1024);
    s = 11'($signed(sum[20:11])) + 11'sd128;
    if (s < 0) begin
      return 8'd0;
    end else if (s > 11'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

endpackage

/* rtl/didct_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module didct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/didct_aan.sv */
// One-dimensional AAN butterfly unit over eight words with one shared multiplier.
`timescale 1ns / 1ps
module didct_aan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  didct_pkg::pass_ctl_t  ctl_i,
  output didct_pkg::pass_ctl_t  ctl_o,
  input  didct_pkg::vec_t       vec_i,
  output didct_pkg::vec_t       vec_o
);
  import didct_pkg::*;

  logic       busy_q, busy_d, done_q, done_d;
  logic [2:0] step_q, step_d;

  word_t e10_q, e11_q, e13_q, d26_q, z10_q, z12_q, t7_q, d11_q, s5_q;
  word_t m1_q, o11_q, z5_q, m3_q, m4_q;
  word_t t0_q, t1_q, t2_q, t3_q, o10_q, t6_q;
  word_t z11, z13, e12, t5, t4;
  word_t mul_a, mul_r;
  logic signed [K_W-1:0] mul_k;
  logic signed [WORD_W+K_W-1:0] prod;

  always_comb begin
    case (step_q)
      3'd1:    begin mul_a = d26_q; mul_k = K_1414;  end
      3'd2:    begin mul_a = d11_q; mul_k = K_1414;  end
      3'd3:    begin mul_a = s5_q;  mul_k = K_1847;  end
      3'd4:    begin mul_a = z12_q; mul_k = K_1082;  end
      default: begin mul_a = z10_q; mul_k = K_M2613; end
    endcase
    prod  = WORD_W'(mul_a) * mul_k;
    mul_r = prod[WORD_W+13:14];
  end

  assign z11 = vec_i[1] + vec_i[7];
  assign z13 = vec_i[5] + vec_i[3];
  assign e12 = m1_q - e13_q;
  assign t5  = o11_q - t6_q;
  assign t4  = o10_q + t5;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (!busy_q) begin
      if (ctl_i.start) begin
        busy_d = 1'b1;
        step_d = 3'd1;
      end
    end else begin
      step_d = step_q + 3'd1;
      if (step_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 3'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && ctl_i.start) begin
      e10_q <= vec_i[0] + vec_i[4];
      e11_q <= vec_i[0] - vec_i[4];
      e13_q <= vec_i[2] + vec_i[6];
      d26_q <= vec_i[2] - vec_i[6];
      z10_q <= vec_i[5] - vec_i[3];
      z12_q <= vec_i[1] - vec_i[7];
      t7_q  <= z11 + z13;
      d11_q <= z11 - z13;
      s5_q  <= (vec_i[5] - vec_i[3]) + (vec_i[1] - vec_i[7]);
    end
    if (busy_q) begin
      case (step_q)
        3'd1: m1_q  <= mul_r;
        3'd2: o11_q <= mul_r;
        3'd3: z5_q  <= mul_r;
        3'd4: m3_q  <= mul_r;
        3'd5: m4_q  <= mul_r;
        3'd6: begin
          t0_q  <= e10_q + e13_q;
          t3_q  <= e10_q - e13_q;
          t1_q  <= e11_q + e12;
          t2_q  <= e11_q - e12;
          o10_q <= m3_q - z5_q;
          t6_q  <= m4_q + z5_q - t7_q;
        end
        default: begin
          vec_o[0] <= t0_q + t7_q;
          vec_o[7] <= t0_q - t7_q;
          vec_o[1] <= t1_q + t6_q;
          vec_o[6] <= t1_q - t6_q;
          vec_o[2] <= t2_q + t5;
          vec_o[5] <= t2_q - t5;
          vec_o[4] <= t3_q + t4;
          vec_o[3] <= t3_q - t4;
        end
      endcase
    end
  end

  assign ctl_o.start = busy_q;
  assign ctl_o.done  = done_q;

endmodule

/* rtl/dequant_idct_8x8.sv */
// Top level of the dequantizing 8x8 AAN inverse DCT.
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | didct_pkg::in_t
//  out     | output    | out_valid_o / out_stall_i| didct_pkg::out_t
// A quant write or a coefficient without block end is taken without a stall.
// A block end starts dequantization, with a read, multiply and write step per
// coefficient, then sixteen 1-D passes through the shared multiplier.
// The input stalls for the whole block; pixel beats wait on out_stall_i.
// Reset clears all coefficients; quant tables are undefined until written.
`timescale 1ns / 1ps
module dequant_idct_8x8 #(
  parameter int QUANT_TABLES = didct_pkg::QUANT_TABLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  didct_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output didct_pkg::out_t  out_data_o
);
  import didct_pkg::*;

  localparam int QAW = $clog2(QUANT_TABLES * 64);

  state_e     state_q, state_d;
  logic [5:0] idx_q, idx_d;
  logic [2:0] line_q, line_d;
  logic [3:0] k_q, k_d;
  logic       row_q, row_d;
  logic [1:0] tab_q, tab_d;
  logic [63:0] valid_q, valid_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q;

  logic        accept, coeff_we, quant_we, load_out;
  logic [15:0] coeff_rdata;
  logic [7:0]  quant_rdata;
  logic [QAW-1:0] quant_waddr, quant_raddr;
  logic        work_we;
  logic [5:0]  work_waddr, work_raddr, line_addr;
  word_t       work_wdata, work_rdata;
  logic signed [CQ_W-1:0] cq_q;
  logic signed [CQ_W+SCALE_W:0] dq_prod;
  vec_t        vec_q, res;
  pass_ctl_t   unit_in, unit_out;

  assign accept   = in_valid_i && !in_stall_o;
  assign coeff_we = accept && in_data_i.func == FUNC_COEFF;
  assign quant_we = accept && in_data_i.func == FUNC_QUANT
                    && int'(in_data_i.table_select) < QUANT_TABLES;
  assign quant_waddr = QAW'({in_data_i.table_select, ZZ_TO_NAT[in_data_i.position]});
  assign quant_raddr = QAW'({tab_q, idx_q});

  didct_ram #(.WIDTH(16), .DEPTH(64)) u_coeff_ram (
    .clk_i, .we_i(coeff_we), .waddr_i(in_data_i.position),
    .wdata_i(in_data_i.coeff_value), .raddr_i(idx_q), .rdata_o(coeff_rdata)
  );

  didct_ram #(.WIDTH(8), .DEPTH(QUANT_TABLES * 64)) u_quant_ram (
    .clk_i, .we_i(quant_we), .waddr_i(quant_waddr),
    .wdata_i(in_data_i.quant_value), .raddr_i(quant_raddr), .rdata_o(quant_rdata)
  );

  assign line_addr  = row_q ? {line_q, k_q[2:0]} : {k_q[2:0], line_q};
  assign dq_prod    = (CQ_W+SCALE_W+1)'(cq_q) * $signed({1'b0, SCALE2[idx_q]});
  assign work_we    = state_q == ST_DQ_WR || (state_q == ST_XFER && !row_q);
  assign work_waddr = state_q == ST_DQ_WR ? idx_q : line_addr;
  assign work_wdata = state_q == ST_DQ_WR
                      ? WORD_W'($signed(dq_prod[CQ_W+SCALE_W:20]))
                      : res[k_q[2:0]];
  assign work_raddr = line_addr;

  didct_ram #(.WIDTH(WORD_W), .DEPTH(64)) u_work_ram (
    .clk_i, .we_i(work_we), .waddr_i(work_waddr),
    .wdata_i(work_wdata), .raddr_i(work_raddr), .rdata_o(work_rdata)
  );

  assign unit_in.start = state_q == ST_GO;
  assign unit_in.done  = 1'b0;

  didct_aan u_aan (
    .clk_i, .rst_ni, .ctl_i(unit_in), .ctl_o(unit_out), .vec_i(vec_q), .vec_o(res)
  );

  assign load_out = state_q == ST_XFER && row_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    line_d  = line_q;
    k_d     = k_q;
    row_d   = row_q;
    tab_d   = tab_q;
    valid_d = valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (coeff_we) begin
          valid_d[in_data_i.position] = 1'b1;
          if (in_data_i.block_end) begin
            tab_d   = int'(in_data_i.table_select) < QUANT_TABLES
                      ? in_data_i.table_select : 2'(QUANT_TABLES - 1);
            idx_d   = 6'd0;
            state_d = ST_DQ_RD;
          end
        end
      end
      ST_DQ_RD:  state_d = ST_DQ_MUL;
      ST_DQ_MUL: state_d = ST_DQ_WR;
      ST_DQ_WR: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd63) begin
          valid_d = '0;
          line_d  = 3'd0;
          row_d   = 1'b0;
          k_d     = 4'd0;
          state_d = ST_LD;
        end else begin
          state_d = ST_DQ_RD;
        end
      end
      ST_LD: begin
        k_d = k_q + 4'd1;
        if (k_q == 4'd8) begin
          state_d = ST_GO;
        end
      end
      ST_GO: state_d = ST_RUN;
      ST_RUN: begin
        if (unit_out.done) begin
          k_d     = 4'd0;
          state_d = ST_XFER;
        end
      end
      ST_XFER: begin
        if (!row_q || load_out) begin
          k_d = k_q + 4'd1;
          if (k_q == 4'd7) begin
            k_d    = 4'd0;
            line_d = line_q + 3'd1;
            state_d = ST_LD;
            if (line_q == 3'd7) begin
              row_d = 1'b1;
              if (row_q) begin
                row_d   = 1'b0;
                state_d = ST_IDLE;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      line_q      <= '0;
      k_q         <= '0;
      row_q       <= 1'b0;
      tab_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      line_q      <= line_d;
      k_q         <= k_d;
      row_q       <= row_d;
      tab_q       <= tab_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DQ_MUL) begin
      cq_q <= valid_q[idx_q]
              ? CQ_W'($signed(coeff_rdata)) * $signed({1'b0, quant_rdata}) : '0;
    end
    if (state_q == ST_LD && k_q != 4'd0) begin
      vec_q[k_q[2:0] - 3'd1] <= work_rdata;
    end
    if (load_out) begin
      out_q.pixel_value <= to_pixel(res[k_q[2:0]]);
      out_q.pixel_index <= {line_q, k_q[2:0]};
      out_q.last        <= line_q == 3'd7 && k_q == 4'd7;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/didct_checker.sv */
// Port-level checker for the dequantizing 8x8 inverse DCT, bound to the top level.
`timescale 1ns / 1ps
module didct_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input didct_pkg::in_t  in_data_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input didct_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled pixel beat changed");

  a_block_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.func && in_data_i.block_end |=> in_stall_o)
    else $error("block end did not start the transform");

  a_mid_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken before the block finished");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.pixel_index == 6'd63)
    else $error("last flag on wrong pixel");

endmodule

bind dequant_idct_8x8 didct_checker u_didct_checker (.*);

/* verif/tb_dequant_idct_8x8.sv */
// Self-checking testbench for the dequantizing 8x8 AAN inverse DCT with a built-in predictor.
`timescale 1ns / 1ps
module tb_dequant_idct_8x8;
  import didct_pkg::*;

  localparam int NTAB = 4;
  localparam int TAIL_CYCLES = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  dequant_idct_8x8 #(.QUANT_TABLES(NTAB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  in_t pending_beats[$];
  out_t pixels_due[$];
  int mismatches = 0;
  int blocks_seen = 0;

  logic [15:0] coeff_mem [64];
  logic [7:0] quant_mem [NTAB][64];
  longint work [64];

  localparam longint SCALE [8] = '{16384, 22725, 21407, 19266, 16384, 12873, 8867, 4520};

  function automatic longint rot(longint a, longint k);
    return (a * k) >>> 14;
  endfunction

  task automatic aan_pass(int b, int st);
    longint i0, i1, i2, i3, i4, i5, i6, i7;
    longint e10, e11, e12, e13, t0, t1, t2, t3, t4, t5, t6, t7;
    longint z5, z10, z11, z12, z13, o10, o11, o12;
    i0 = work[b]; i1 = work[b + st]; i2 = work[b + 2 * st]; i3 = work[b + 3 * st];
    i4 = work[b + 4 * st]; i5 = work[b + 5 * st]; i6 = work[b + 6 * st];
    i7 = work[b + 7 * st];
    e10 = i0 + i4; e11 = i0 - i4; e13 = i2 + i6;
    e12 = rot(i2 - i6, 23170) - e13;
    t0 = e10 + e13; t3 = e10 - e13; t1 = e11 + e12; t2 = e11 - e12;
    z13 = i5 + i3; z10 = i5 - i3; z11 = i1 + i7; z12 = i1 - i7;
    t7 = z11 + z13;
    o11 = rot(z11 - z13, 23170);
    z5 = rot(z10 + z12, 30274);
    o10 = rot(z12, 17734) - z5;
    o12 = rot(z10, -42813) + z5;
    t6 = o12 - t7; t5 = o11 - t6; t4 = o10 + t5;
    work[b] = t0 + t7;          work[b + 7 * st] = t0 - t7;
    work[b + st] = t1 + t6;     work[b + 6 * st] = t1 - t6;
    work[b + 2 * st] = t2 + t5; work[b + 5 * st] = t2 - t5;
    work[b + 4 * st] = t3 + t4; work[b + 3 * st] = t3 - t4;
  endtask

  function automatic logic [7:0] sample_of(longint v);
    longint p;
    logic signed [9:0] w;
    int s;
    p = (v + 1024) >>> 11;
    w = p[9:0];
    s = int'(w) + 128;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  task automatic predict_beat(in_t b);
    int tab;
    longint c;
    out_t o;
    if (b.func == FUNC_QUANT) begin
      if (b.table_select < NTAB) quant_mem[b.table_select][ZZ_TO_NAT[b.position]] = b.quant_value;
      return;
    end
    coeff_mem[b.position] = b.coeff_value;
    if (!b.block_end) return;
    tab = (b.table_select < NTAB) ? b.table_select : NTAB - 1;
    for (int i = 0; i < 64; i++) begin
      c = longint'($signed(coeff_mem[i]));
      work[i] = (c * longint'(quant_mem[tab][i]) * SCALE[i / 8] * SCALE[i % 8]) >>> 20;
    end
    for (int i = 0; i < 8; i++) aan_pass(i, 8);
    for (int i = 0; i < 8; i++) aan_pass(i * 8, 1);
    for (int i = 0; i < 64; i++) begin
      o.pixel_value = sample_of(work[i]);
      o.pixel_index = 6'(i);
      o.last = (i == 63);
      pixels_due.push_back(o);
      coeff_mem[i] = '0;
    end
    blocks_seen++;
  endtask

  function automatic bit quiet();
    return blocks_seen >= 4 && blocks_seen < 8;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_t nxt;
    logic v;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      v = in_valid_i;
      nxt = in_data_i;
      if (in_valid_i && !in_stall_o) begin
        predict_beat(in_data_i);
        v = 1'b0;
      end
      if (!v && pending_beats.size() != 0 && (quiet() || $urandom_range(99) >= 17)) begin
        nxt = pending_beats.pop_front();
        v = 1'b1;
      end
      in_valid_i <= v;
      in_data_i <= nxt;
    end
  end

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          report("unexpected beat, index", out_data_o.pixel_index, -1);
        end else begin
          want = pixels_due.pop_front();
          if (out_data_o.pixel_value !== want.pixel_value)
            report("pixel_value", out_data_o.pixel_value, want.pixel_value);
          if (out_data_o.pixel_index !== want.pixel_index)
            report("pixel_index", out_data_o.pixel_index, want.pixel_index);
          if (out_data_o.last !== want.last)
            report("last", out_data_o.last, want.last);
        end
      end
      out_stall_i <= !quiet() && ($urandom_range(99) < 17);
    end
  end

  task automatic add_quant(int t, int pos, int val);
    in_t b;
    b = '0;
    b.func = FUNC_QUANT;
    b.table_select = 2'(t);
    b.position = 6'(pos);
    b.quant_value = 8'(val);
    b.coeff_value = 16'($urandom);
    b.block_end = 1'($urandom);
    pending_beats.push_back(b);
  endtask

  task automatic add_coeff(int t, int pos, int val, bit fin);
    in_t b;
    b = '0;
    b.func = FUNC_COEFF;
    b.table_select = 2'(t);
    b.position = 6'(pos);
    b.quant_value = 8'($urandom);
    b.coeff_value = 16'(val);
    b.block_end = fin;
    pending_beats.push_back(b);
  endtask

  function automatic int rand_coeff();
    if ($urandom_range(2) == 0) return int'($signed(16'($urandom)));
    return int'($urandom_range(256)) - 128;
  endfunction

  initial begin
    int qv;
    for (int i = 0; i < 64; i++) coeff_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 64; p++) begin
      case (p % 4)
        0: qv = 255;
        1: qv = 1;
        2: qv = int'($urandom_range(255, 1));
        default: qv = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(255));
      endcase
      add_quant(0, p, qv);
    end
    add_coeff(0, 0, 32767, 1'b1);
    add_coeff(3, 0, -32768, 1'b0);
    add_coeff(1, 9, -32768, 1'b0);
    add_coeff(0, 63, 32767, 1'b1);
    add_coeff(2, 5, 100, 1'b0);
    add_coeff(2, 5, -200, 1'b0);
    add_coeff(0, 5, 7, 1'b1);
    add_coeff(0, 0, 0, 1'b1);
    add_coeff(0, 7, 32767, 1'b0);
    add_coeff(2, 56, -32768, 1'b0);
    add_coeff(0, 27, 1, 1'b1);

    for (int n = 0; n < 34; n++) begin
      if ($urandom_range(9) == 0) add_quant($urandom_range(3), $urandom_range(63), $urandom);
      else if ($urandom_range(5) == 0) add_coeff(0, $urandom_range(63), rand_coeff(), 1'b1);
      else add_coeff($urandom_range(3), $urandom_range(63), rand_coeff(), 1'b0);
    end
    add_coeff(0, $urandom_range(63), rand_coeff(), 1'b1);

    do @(posedge clk_i); while (pending_beats.size() != 0 || in_valid_i);
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pixels_due.size() == 0) begin
      $display("dequant_idct_8x8 test passed");
    end else begin
      $display("dequant_idct_8x8 test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("dequant_idct_8x8 test failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/didct_pkg.sv
rtl/didct_ram.sv
rtl/didct_aan.sv
rtl/dequant_idct_8x8.sv
rtl/didct_checker.sv
verif/tb_dequant_idct_8x8.sv
